/* rtl/core/sfe_pkg.sv */
// Shared package for the stereo feedforward echo block.
// Holds default sizes, config register codes and the lane control struct.
// No dependencies.
`default_nettype none

package sfe_pkg;

    // Default sizes for the top-level parameters
    localparam int MAX_DELAY_DEF   = 65536;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed register formats
    localparam int GAIN_BITS     = 16;
    localparam int GAIN_FRAC     = 14;
    localparam int DELAY_BITS    = 16;
    localparam int CFG_DATA_BITS = 16;

    // Config register index
    typedef enum logic [0:0] {
        CFG_DELAY = 1'b0,
        CFG_GAIN  = 1'b1
    } t_cfg_idx;

    // Per-stage controls shared by both channel lanes
    typedef struct packed {
        logic ld_s1;     // item transfer in: write memory, issue read
        logic ld_s2;     // stage 1 moves into stage 2
        logic zero_s1;   // zero delay: use current sample as delayed one
        logic pass_s2;   // warm-up: output equals input
    } t_lane_ctl;

endpackage

`default_nettype wire

/* rtl/core/sfe_in_if.sv */
// Input channel interface: valid/ready with one stereo sample pair.
// Depends on sfe_pkg for the default sample width.
`default_nettype none

interface sfe_in_if #(
    parameter int SAMPLE_BITS = sfe_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          last_sample;

    modport source (output valid, output left_in, output right_in, output last_sample,
                    input ready);
    modport sink   (input valid, input left_in, input right_in, input last_sample,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/sfe_out_if.sv */
// Output channel interface: valid/ready with one processed stereo pair.
// Depends on sfe_pkg for the default sample width.
`default_nettype none

interface sfe_out_if #(
    parameter int SAMPLE_BITS = sfe_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          last_out;

    modport source (output valid, output left_out, output right_out, output last_out,
                    input ready);
    modport sink   (input valid, input left_out, input right_out, input last_out,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/stereo_feedforward_echo.sv */
// Top level of the stereo feedforward echo: pointers, warm-up, pipeline control.
// Depends on sfe_pkg, sfe_in_if, sfe_out_if, sfe_lane and sfe_merge.
//
// Usage:
//   i_in  : valid/ready sink, one stereo pair (left_in, right_in, last_sample)
//           per transfer. o_out : valid/ready source, one result pair per input.
//   Config: i_cfg_we with i_cfg_idx (CFG_DELAY, CFG_GAIN) and i_cfg_data,
//           written only while no pair is in flight.
//   Each output is x + g * x[n - D] in Q2.14, truncated toward zero and
//   saturated; until D pairs of the current file have arrived the input passes
//   through. A pair with last_sample set restarts the warm-up.
//   Path: each accepted pair passes the memory read register, the multiply
//   register and the output register, which drives o_out.valid.
//   Throughput: one pair per cycle unless the output stalls; both lanes read and
//   write their delay memory once per pair with a single write and a single read port.
//   Reset clears the write pointer, warm-up count, config registers and all
//   valid flags; the delay memory is not cleared, since warm-up never reads
//   an entry older than the current file.
//   When the receiver stalls, the output register holds its pair and the
//   three stages fill; i_in.ready drops only once every stage is full.
`default_nettype none

module stereo_feedforward_echo #(
    parameter int SAMPLE_BITS = sfe_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_DELAY   = sfe_pkg::MAX_DELAY_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  sfe_pkg::t_cfg_idx                     i_cfg_idx,
    input  wire  [sfe_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    sfe_in_if.sink                                i_in,
    sfe_out_if.source                             o_out
);
    import sfe_pkg::*;

    localparam int AW  = $clog2(MAX_DELAY);
    localparam int WCW = $clog2(MAX_DELAY + 1);
    localparam int CW  = ((AW > DELAY_BITS) ? AW : DELAY_BITS) + 1;
    localparam logic [CW-1:0] D_MAX = CW'(MAX_DELAY - 1);

    // Config registers
    logic        [DELAY_BITS-1:0] r_delay;
    logic signed [GAIN_BITS-1:0]  r_gain;

    // Pointer and warm-up state
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  n_wp;
    logic [WCW-1:0] r_warm;
    logic [WCW-1:0] n_warm;

    // Pipeline flags
    logic r_v1, r_zero1, r_pass1, r_last1;
    logic r_v2, r_pass2, r_last2;
    logic n_v1, n_v2;

    logic [CW-1:0] w_d_ext;
    logic [AW-1:0] w_d;
    logic [AW-1:0] w_rp;
    logic          w_zero;
    logic          w_pass;
    logic          w_accept;
    logic          w_adv1, w_adv2;
    logic          w_rdy1, w_rdy2, w_rdy3;

    t_lane_ctl                     w_ctl;
    logic signed [SAMPLE_BITS-1:0] w_y_left;
    logic signed [SAMPLE_BITS-1:0] w_y_right;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= '0;
            r_gain  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DELAY: r_delay <= i_cfg_data[DELAY_BITS-1:0];
                CFG_GAIN:  r_gain  <= signed'(i_cfg_data[GAIN_BITS-1:0]);
                default:   ;
            endcase
        end
    end

    // Clamped delay, read address, warm-up and zero-delay flags
    always_comb begin
        w_d_ext = CW'(r_delay);
        w_d     = (w_d_ext > D_MAX) ? D_MAX[AW-1:0] : w_d_ext[AW-1:0];
        if (r_wp >= w_d) begin
            w_rp = r_wp - w_d;
        end else begin
            w_rp = AW'((AW+1)'(r_wp) + (AW+1)'(MAX_DELAY) - (AW+1)'(w_d));
        end
        w_zero = (w_d == '0);
        w_pass = (r_warm < WCW'(w_d));
    end

    // Stall chain: a stage advances when the next one is empty or advancing
    always_comb begin
        w_rdy2   = !r_v2 || w_rdy3;
        w_rdy1   = !r_v1 || w_rdy2;
        w_adv2   = r_v2 && w_rdy3;
        w_adv1   = r_v1 && w_rdy2;
        w_accept = i_in.valid && w_rdy1;
        n_v1     = w_accept ? 1'b1 : (w_adv1 ? 1'b0 : r_v1);
        n_v2     = w_adv1 ? 1'b1 : (w_adv2 ? 1'b0 : r_v2);
    end

    assign i_in.ready = w_rdy1;

    // Pointer and warm-up update per transfer
    always_comb begin
        n_wp   = r_wp;
        n_warm = r_warm;
        if (w_accept) begin
            n_wp = (r_wp == AW'(MAX_DELAY - 1)) ? '0 : r_wp + AW'(1);
            if (i_in.last_sample) begin
                n_warm = '0;
            end else if (r_warm != WCW'(MAX_DELAY)) begin
                n_warm = r_warm + WCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_warm <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            r_wp   <= n_wp;
            r_warm <= n_warm;
            r_v1   <= n_v1;
            r_v2   <= n_v2;
        end
    end

    // Flags travel with the samples
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_zero1 <= w_zero;
            r_pass1 <= w_pass;
            r_last1 <= i_in.last_sample;
        end
        if (w_adv1) begin
            r_pass2 <= r_pass1;
            r_last2 <= r_last1;
        end
    end

    always_comb begin
        w_ctl.ld_s1   = w_accept;
        w_ctl.ld_s2   = w_adv1;
        w_ctl.zero_s1 = r_zero1;
        w_ctl.pass_s2 = r_pass2;
    end

    // Channel lanes
    sfe_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_DELAY   (MAX_DELAY)
    ) u_lane_left (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_wr_addr (r_wp),
        .i_rd_addr (w_rp),
        .i_sample  (i_in.left_in),
        .i_gain    (r_gain),
        .o_y       (w_y_left)
    );

    sfe_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_DELAY   (MAX_DELAY)
    ) u_lane_right (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_wr_addr (r_wp),
        .i_rd_addr (w_rp),
        .i_sample  (i_in.right_in),
        .i_gain    (r_gain),
        .o_y       (w_y_right)
    );

    // Output register joining both lanes
    sfe_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_v2),
        .i_left      (w_y_left),
        .i_right     (w_y_right),
        .i_last      (r_last2),
        .o_ready     (w_rdy3),
        .i_out_ready (o_out.ready),
        .o_valid     (o_out.valid),
        .o_left      (o_out.left_out),
        .o_right     (o_out.right_out),
        .o_last      (o_out.last_out)
    );

endmodule

`default_nettype wire

/* rtl/core/sfe_lane.sv */
// One channel lane: delay memory, gain multiply, truncate and saturate.
// Depends on sfe_pkg (t_lane_ctl, gain format).
`default_nettype none

module sfe_lane #(
    parameter int SAMPLE_BITS = sfe_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_DELAY   = sfe_pkg::MAX_DELAY_DEF
) (
    input  wire                                    i_clk,
    input  sfe_pkg::t_lane_ctl                     i_ctl,
    input  wire  [$clog2(MAX_DELAY)-1:0]           i_wr_addr,
    input  wire  [$clog2(MAX_DELAY)-1:0]           i_rd_addr,
    input  wire  signed [SAMPLE_BITS-1:0]          i_sample,
    input  wire  signed [sfe_pkg::GAIN_BITS-1:0]   i_gain,
    output logic signed [SAMPLE_BITS-1:0]          o_y
);
    import sfe_pkg::*;

    localparam int PW   = SAMPLE_BITS + GAIN_BITS;
    localparam int ACCW = PW + 1;
    localparam logic signed [ACCW-1:0] SAT_HI =
        ACCW'((longint'(1) <<< (SAMPLE_BITS - 1)) - longint'(1));
    localparam logic signed [ACCW-1:0] SAT_LO = -SAT_HI - ACCW'(1);

    logic signed [SAMPLE_BITS-1:0] mem [MAX_DELAY];

    logic signed [SAMPLE_BITS-1:0] r_cur1;
    logic signed [SAMPLE_BITS-1:0] r_old1;
    logic signed [SAMPLE_BITS-1:0] r_cur2;
    logic signed [PW-1:0]          r_prod2;

    logic signed [SAMPLE_BITS-1:0] w_old;
    logic signed [PW-1:0]          w_prod;
    logic signed [ACCW-1:0]        w_acc;
    logic signed [ACCW-1:0]        w_fl;
    logic signed [ACCW-1:0]        w_rnd;
    logic signed [SAMPLE_BITS-1:0] w_sat;

    // Delay memory: write current sample, registered read of the delayed one
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_s1) begin
            mem[i_wr_addr] <= i_sample;
            r_old1         <= mem[i_rd_addr];
            r_cur1         <= i_sample;
        end
    end

    // Stage 1: gain multiply
    always_comb begin
        w_old  = i_ctl.zero_s1 ? r_cur1 : r_old1;
        w_prod = PW'(w_old) * PW'(i_gain);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_s2) begin
            r_cur2  <= r_cur1;
            r_prod2 <= w_prod;
        end
    end

    // Stage 2: sum in Q.14, truncate toward zero, saturate, or pass the input through in warm-up
    always_comb begin
        w_acc = (ACCW'(r_cur2) <<< GAIN_FRAC) + ACCW'(r_prod2);
        w_fl  = w_acc >>> GAIN_FRAC;
        if (w_acc[ACCW-1] && (|w_acc[GAIN_FRAC-1:0])) begin
            w_rnd = w_fl + ACCW'(1);
        end else begin
            w_rnd = w_fl;
        end
        if (w_rnd > SAT_HI) begin
            w_sat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (w_rnd < SAT_LO) begin
            w_sat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            w_sat = w_rnd[SAMPLE_BITS-1:0];
        end
        o_y = i_ctl.pass_s2 ? r_cur2 : w_sat;
    end

endmodule

`default_nettype wire

/* rtl/core/sfe_merge.sv */
// Output stage: joins both lane results and the last flag in one register.
// Depends on sfe_pkg for the default sample width.
`default_nettype none

module sfe_merge #(
    parameter int SAMPLE_BITS = sfe_pkg::SAMPLE_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    input  wire  signed [SAMPLE_BITS-1:0] i_left,
    input  wire  signed [SAMPLE_BITS-1:0] i_right,
    input  wire                           i_last,
    output logic                          o_ready,
    input  wire                           i_out_ready,
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_left,
    output logic signed [SAMPLE_BITS-1:0] o_right,
    output logic                          o_last
);
    import sfe_pkg::*;

    logic                          r_valid;
    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_right;
    logic                          r_last;
    logic                          n_valid;
    logic                          w_load;

    // Free when empty or when the held pair transfers this cycle
    always_comb begin
        o_ready = !r_valid || i_out_ready;
        w_load  = i_valid && o_ready;
        n_valid = w_load ? 1'b1 : (i_out_ready ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_left  <= i_left;
            r_right <= i_right;
            r_last  <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_left  = r_left;
    assign o_right = r_right;
    assign o_last  = r_last;

endmodule

`default_nettype wire

/* rtl/core/sfe_check.sv */
// Port-level checker for stereo_feedforward_echo, attached by bind.
// Depends on the top level's port names only.
`default_nettype none

module sfe_check (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_valid,
    input wire i_in_ready,
    input wire i_out_valid,
    input wire i_out_ready,
    input wire i_out_last
);
    // Pairs accepted but not yet delivered
    logic [2:0] r_inflight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 3'((i_in_valid && i_in_ready) ? 1 : 0)
                                     - 3'((i_out_valid && i_out_ready) ? 1 : 0);
        end
    end

    // Output pairs never outrun input pairs
    a_no_spurious_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_inflight != 3'd0))
        else $error("output pair without a matching input pair");

    // At most three pairs are held in the pipeline
    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd3)
        else $error("more pairs in flight than pipeline stages");

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // A stalled result stays offered with the same last flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_last)))
        else $error("stalled output pair dropped or changed");

endmodule

bind stereo_feedforward_echo sfe_check u_sfe_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_last  (o_out.last_out)
);

`default_nettype wire
